/* rtl/core/mbp_pkg.sv */
package mbp_pkg;

    // Longest code accepted in one request; a larger bit_count is clipped to this.
    localparam int MAX_CODE_BITS = 32;

    localparam int CodeW   = 32;                 // width of code_value
    localparam int CntW    = 6;                  // width of bit_count
    localparam int CodeLim = (MAX_CODE_BITS < CodeW) ? MAX_CODE_BITS : CodeW;
    localparam int WinW    = CodeW + 8;          // 7 pending bits + code + guard bit
    localparam int TotW    = 6;                  // holds up to 7 + CodeW
    localparam int InDataW = 40;                 // code + count, padded to bytes

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    typedef struct packed {
        logic load;      // take the request at the input
        logic emit;      // move the top byte of the window to the output
    } mbp_cmd_t;

    typedef struct packed {
        logic load_emits;  // request at the input completes at least one byte
        logic last_byte;   // the byte at the top of the window is the last one
        logic slot_free;   // output register can take a byte this cycle
    } mbp_sts_t;

endpackage

/* rtl/core/mbp_ctrl.sv */
module mbp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  mbp_pkg::mbp_sts_t sts,
    output logic              s_ready,
    output mbp_pkg::mbp_cmd_t cmd
);
    import mbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (sts.load_emits) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (sts.slot_free) begin
                    cmd.emit = 1'b1;
                    if (sts.last_byte) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/mbp_dp.sv */
module mbp_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [mbp_pkg::InDataW-1:0]  s_data,
    input  logic                         s_user,
    input  mbp_pkg::mbp_cmd_t            cmd,
    output mbp_pkg::mbp_sts_t            sts,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [7:0]                   m_data,
    output logic                         m_last
);
    import mbp_pkg::*;

    // Window holds the unsent bits left aligned; everything below them is zero.
    logic [WinW-1:0]  win_reg, win_next;
    logic [TotW-1:0]  total_reg, total_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg;
    logic             m_last_reg;

    logic [CodeW-1:0] code;
    logic [CntW-1:0]  cnt_raw, cnt, sh;
    logic [CodeW-1:0] code_left;
    logic [WinW-1:0]  code_ext;
    logic [TotW-1:0]  load_total;
    logic [WinW-1:0]  load_win;
    op_t              op;

    assign code    = s_data[CodeW-1:0];
    assign cnt_raw = s_data[CodeW +: CntW];
    assign op      = op_t'(s_user);

    always_comb begin
        cnt = (cnt_raw > CntW'(CodeLim)) ? CntW'(CodeLim) : cnt_raw;
        // left-justify the code; shifting out the top drops the unused high bits
        sh        = CntW'(CodeW) - cnt;
        code_left = code << sh;
        code_ext  = {code_left, 8'b0};
        if (op == OP_FLUSH) begin
            load_win   = win_reg;
            load_total = (total_reg != '0) ? TotW'(8) : '0;
        end else begin
            load_win   = win_reg | (code_ext >> total_reg[2:0]);
            load_total = total_reg + TotW'(cnt);
        end
    end

    assign sts.load_emits = (load_total >= TotW'(8));
    assign sts.last_byte  = (total_reg < TotW'(16));
    assign sts.slot_free  = !m_valid_reg || m_ready;

    always_comb begin
        win_next     = win_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.load) begin
            win_next   = load_win;
            total_next = load_total;
        end else if (cmd.emit) begin
            win_next     = win_reg << 8;
            total_next   = total_reg - TotW'(8);
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            win_reg     <= win_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= win_reg[WinW-1 -: 8];
            m_last_reg <= sts.last_byte;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

endmodule

/* rtl/core/msb_first_bit_packer.sv */
// MSB-first bit packer: each append request adds the low bit_count bits of
// code_value (clipped to 32) to the bit stream, and every full byte leaves on
// the master side with the earliest bit in bit 7; tlast marks the final byte
// a request produced. A flush request zero-pads a partial byte and sends it.
// Up to seven bits stay pending between requests. Requests are taken one at
// a time: after the accept, the controller sends one byte per cycle from a
// 40-bit window while m_axis_tready allows, and takes no new request until
// the request's final byte has been handed to the output register.
module msb_first_bit_packer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [mbp_pkg::InDataW-1:0]  s_axis_tdata,  // code_value[31:0], bit_count[37:32]
    input  logic                         s_axis_tuser,  // operation
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,  // out_byte[7:0]
    output logic                         m_axis_tlast
);
    import mbp_pkg::*;

    mbp_cmd_t cmd;
    mbp_sts_t sts;

    mbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .sts     (sts),
        .s_ready (s_axis_tready),
        .cmd     (cmd)
    );

    mbp_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_axis_tdata),
        .s_user  (s_axis_tuser),
        .cmd     (cmd),
        .sts     (sts),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_data  (m_axis_tdata),
        .m_last  (m_axis_tlast)
    );

endmodule

/* rtl/core/mbp_chk.sv */
module mbp_chk (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [mbp_pkg::InDataW-1:0]  s_axis_tdata,
    input logic                         s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [7:0]                   m_axis_tdata,
    input logic                         m_axis_tlast
);
    import mbp_pkg::*;

    logic s_acc;
    logic is_append;

    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign is_append = (op_t'(s_axis_tuser) == OP_APPEND);

    // stalled output byte holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output byte changed while stalled");

    // an append of a full byte or more must produce output before the next request
    a_append_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && is_append && (s_axis_tdata[CodeW +: CntW] >= CntW'(8)) |=> !s_axis_tready)
        else $error("append of a full byte did not block for output");

    // an empty append leaves the block ready
    a_empty_append: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && is_append && (s_axis_tdata[CodeW +: CntW] == '0) |=> s_axis_tready)
        else $error("empty append stalled the input");

    // while a request still has bytes to send, no new request is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready in the middle of a request's bytes");

endmodule

bind msb_first_bit_packer mbp_chk u_mbp_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* bench/msb_first_bit_packer_tb.sv */
`timescale 1ns / 1ps

module msb_first_bit_packer_tb;
    import mbp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [InDataW-1:0]   s_axis_tdata;   // code_value[31:0], bit_count[37:32]
    logic                 s_axis_tuser;   // operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;   // out_byte[7:0]
    logic                 m_axis_tlast;   // last_of_item

    // predictor state: pending bits right aligned, earliest in the top used position
    logic [6:0]           pend_bits;
    logic [2:0]           pend_cnt;
    out_byte_t            exp_bytes[$];
    out_byte_t            got_byte;
    out_byte_t            want_byte;

    int                   errors;
    int                   quiet_cycles;
    int                   sink_hold;
    bit                   idle_en;

    msb_first_bit_packer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 aclk = ~aclk;

    task automatic note_error(input string msg);
        if (errors < 10)
            $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // bytes completed by one request; tlast goes on the final byte of the request
    task automatic pack_predict(input op_t op, input logic [31:0] code,
                                input logic [5:0] cnt);
        logic [63:0] acc;
        logic [63:0] mask;
        int          nbits;
        int          total;
        int          made;
        out_byte_t   rec;
        made = 0;
        if (op == OP_FLUSH) begin
            if (pend_cnt != 0) begin
                acc = {57'd0, pend_bits} << (8 - pend_cnt);
                rec.data = acc[7:0];
                rec.last = 1'b1;
                exp_bytes.push_back(rec);
                pend_bits = '0;
                pend_cnt  = '0;
            end
        end else begin
            nbits = (cnt > CodeLim) ? CodeLim : int'(cnt);
            if (nbits != 0) begin
                mask  = (64'd1 << nbits) - 64'd1;
                acc   = ({57'd0, pend_bits} << nbits) | ({32'd0, code} & mask);
                total = pend_cnt + nbits;
                while (total >= 8) begin
                    rec.data = 8'(acc >> (total - 8));
                    rec.last = 1'b0;
                    exp_bytes.push_back(rec);
                    made++;
                    total -= 8;
                end
                if (made > 0)
                    exp_bytes[$].last = 1'b1;
                pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
                pend_cnt  = 3'(total);
            end
        end
    endtask

    // tvalid stays high from one request to the next unless a gap is drawn
    task automatic send_req(input op_t op, input logic [31:0] code, input logic [5:0] cnt);
        while (idle_en && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, cnt, code};
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
        pack_predict(op, code, cnt);
    endtask

    function automatic logic [5:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 6'd0;
        if (r < 12)
            return 6'($urandom_range(63, 33));
        return 6'($urandom_range(32, 1));
    endfunction

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 10)
                send_req(OP_FLUSH, $urandom, 6'($urandom));
            else
                send_req(OP_APPEND, $urandom, pick_count());
        end
    endtask

    task automatic test_field_extremes();
        send_req(OP_APPEND, 32'h0000_00A5, 6'd8);
        send_req(OP_APPEND, 32'hFFFF_FFFF, 6'd32);
        send_req(OP_APPEND, 32'h0000_0000, 6'd32);
        send_req(OP_APPEND, 32'h0000_0001, 6'd1);
        send_req(OP_APPEND, 32'h7FFF_FFFF, 6'd31);
        send_req(OP_APPEND, 32'h0000_0055, 6'd7);
        send_req(OP_FLUSH,  32'h0000_0000, 6'd0);
        send_req(OP_APPEND, 32'h0000_0003, 6'd2);
        send_req(OP_APPEND, 32'hDEAD_BEEF, 6'd16);
        send_req(OP_FLUSH,  32'h0000_0000, 6'd0);
    endtask

    task automatic test_special_cases();
        // zero count: nothing appended even with all code bits set
        send_req(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
        send_req(OP_APPEND, 32'h0000_0005, 6'd3);
        send_req(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
        // counts above 32 clip to 32
        send_req(OP_APPEND, 32'h1234_5678, 6'd63);
        send_req(OP_APPEND, 32'h8765_4321, 6'd33);
        // bits above the count are dropped
        send_req(OP_APPEND, 32'hFFFF_FFFE, 6'd1);
        send_req(OP_APPEND, 32'hFFFF_FF00, 6'd4);
        // flush operands are don't-care
        send_req(OP_FLUSH,  32'hFFFF_FFFF, 6'd63);
        // flush with nothing pending: no byte
        send_req(OP_FLUSH,  32'hA5A5_A5A5, 6'd17);
        send_req(OP_FLUSH,  32'h0000_0000, 6'd0);
        send_req(OP_APPEND, 32'h0000_007F, 6'd7);
        send_req(OP_APPEND, 32'h0000_0001, 6'd1);
        send_req(OP_APPEND, 32'h0000_0001, 6'd1);
        send_req(OP_FLUSH,  32'h0000_0000, 6'd0);
    endtask

    task automatic test_no_gap_stream();
        idle_en = 1'b0;
        send_random(40);
        idle_en = 1'b1;
    endtask

    task automatic test_random_stream();
        send_random(44);
    endtask

    // sink holds off while full-width codes keep coming, so the input must stall
    task automatic test_backpressure();
        idle_en   = 1'b0;
        sink_hold = 150;
        for (int i = 0; i < 12; i++)
            send_req(OP_APPEND, $urandom, 6'd32);
        send_req(OP_APPEND, $urandom, 6'd5);
        send_req(OP_FLUSH, $urandom, 6'($urandom));
        idle_en = 1'b1;
    endtask

    // result side: check each accepted byte, then draw tready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_byte.data = m_axis_tdata;
            got_byte.last = m_axis_tlast;
            if (exp_bytes.size() == 0) begin
                note_error($sformatf("unexpected byte %02h last %0b",
                                     got_byte.data, got_byte.last));
            end else begin
                want_byte = exp_bytes.pop_front();
                if (got_byte.data !== want_byte.data)
                    note_error($sformatf("byte: expected %02h, got %02h",
                                         want_byte.data, got_byte.data));
                if (got_byte.last !== want_byte.last)
                    note_error($sformatf("tlast: expected %0b, got %0b",
                                         want_byte.last, got_byte.last));
            end
        end
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold--;
        end else begin
            m_axis_tready <= !idle_en || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000) begin
            $display("msb_first_bit_packer verification failed");
            $finish;
        end
    end

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_APPEND;
        m_axis_tready = 1'b0;
        pend_bits     = '0;
        pend_cnt      = '0;
        errors        = 0;
        quiet_cycles  = 0;
        sink_hold     = 0;
        idle_en       = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_special_cases();
        test_no_gap_stream();
        test_random_stream();
        test_backpressure();

        s_axis_tvalid <= 1'b0;
        while (exp_bytes.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("msb_first_bit_packer verification clean");
        else
            $display("msb_first_bit_packer verification failed");
        $finish;
    end

endmodule
